@@ src/msbs_pkg.sv @@
// ----------------------------------------------------------------------------
// msbs_pkg
// Shared constants and types for the multi-scale box sum block: window
// geometry, per-channel sum widths, the line store word and the result record.
// ----------------------------------------------------------------------------
package msbs_pkg;

    localparam int WIN         = 64;
    localparam int HALF        = 32;
    localparam int QUARTER     = 16;
    localparam int LINE_ROWS   = 64;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WIN_BITS    = 6;
    localparam int ROW_BITS    = 4;
    localparam int LANES       = LINE_ROWS / QUARTER;
    localparam int LANE_BITS   = 2;

    localparam int NUM_CH      = 3;
    localparam int PIX_W       = 8;

    // column sums over 16, 32 and 64 rows
    localparam int C16_W       = 12;
    localparam int C32_W       = 13;
    localparam int C64_W       = 14;

    // window sums
    localparam int S16_W       = 16;
    localparam int S32_W       = 18;
    localparam int S64_W       = 20;

    localparam int OX_W        = 10;
    localparam int OY_W        = 12;
    localparam int IMG_W_W     = 11;
    localparam int IMG_H_W     = 13;
    localparam int CFG_W       = 13;

    localparam int IMG_W_RESET = 1024;
    localparam int IMG_H_RESET = 1024;

    typedef logic [PIX_W-1:0] t_chan;
    typedef t_chan [NUM_CH-1:0] t_pixel;
    typedef t_pixel [LANES-1:0] t_ls_word;

    typedef struct packed {
        logic [NUM_CH-1:0][C16_W-1:0] c16;
        logic [NUM_CH-1:0][C32_W-1:0] c32;
        logic [NUM_CH-1:0][C64_W-1:0] c64;
    } t_col_rec;

    typedef struct packed {
        logic [OX_W-1:0]              origin_x;
        logic [OY_W-1:0]              origin_y;
        logic [NUM_CH-1:0][S16_W-1:0] s16;
        logic [NUM_CH-1:0][S32_W-1:0] s32;
        logic [NUM_CH-1:0][S64_W-1:0] s64;
    } t_result;

    typedef enum logic {
        CFG_IMG_WIDTH  = 1'b0,
        CFG_IMG_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

@@ src/msbs_line_store.sv @@
// ----------------------------------------------------------------------------
// msbs_line_store
// Pixel line store for the last 64 rows. Rows are split into four lanes of
// 16 rows; one word holds the same column and row-in-lane of all four lanes,
// so one read returns the rows 64, 48 and 32 above the current pixel while
// the current pixel is written into its own lane (read-first).
// ----------------------------------------------------------------------------
module msbs_line_store
    import msbs_pkg::*;
#(
    parameter int XW = 10
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [LANE_BITS-1:0]  i_lane,
    input  logic [XW+ROW_BITS-1:0] i_addr,
    input  t_pixel                i_wdata,
    output t_ls_word              o_rdata
);

    localparam int DEPTH = QUARTER << XW;

    t_ls_word r_mem [DEPTH];
    t_ls_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mem[i_addr][i_lane] <= i_wdata;
            r_rdata               <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/multi_scale_box_sum_top.sv @@
// ----------------------------------------------------------------------------
// multi_scale_box_sum_top
// Per-channel 16x16, 32x32 and 64x64 box sums over a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while o_in_stall is low. For every origin whose
// 64x64 window fits the image, one transaction carries the three box sums per
// channel; after the window's bottom-right pixel is accepted it passes through
// the stage 1, stage 2 and output registers. Throughput is set by the line
// store (one read-write word per pixel) and the column-sum memory (one
// read-modify-write per pixel); the same column entry is never touched twice
// within 64 pixels, so the three-stage pipeline needs no forwarding. The input
// stalls only while both the output register and the skid register hold
// results. No clearing pass after reset: column sums are rebuilt on the first
// row of every frame. A configuration write restarts the frame at pixel (0, 0).
// ----------------------------------------------------------------------------
module multi_scale_box_sum_top
    import msbs_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PIX_W-1:0]   i_chan_first,
    input  logic [PIX_W-1:0]   i_chan_second,
    input  logic [PIX_W-1:0]   i_chan_third,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OX_W-1:0]    o_origin_x,
    output logic [OY_W-1:0]    o_origin_y,
    output logic [S16_W-1:0]   o_sum16_first,
    output logic [S16_W-1:0]   o_sum16_second,
    output logic [S16_W-1:0]   o_sum16_third,
    output logic [S32_W-1:0]   o_sum32_first,
    output logic [S32_W-1:0]   o_sum32_second,
    output logic [S32_W-1:0]   o_sum32_third,
    output logic [S64_W-1:0]   o_sum64_first,
    output logic [S64_W-1:0]   o_sum64_second,
    output logic [S64_W-1:0]   o_sum64_third
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int XE    = XW + 1;
    localparam int CDEP  = 2 ** XW;

    // configuration and position
    logic [IMG_W_W-1:0] r_img_w;
    logic [IMG_H_W-1:0] r_img_h;
    logic [XW-1:0]      w_last_x;
    logic [OY_W-1:0]    w_last_y;
    logic [XW-1:0]      r_pos_x;
    logic [OY_W-1:0]    r_pos_y;
    logic [XE-1:0]      w_x_ext;

    logic               en;
    logic               in_acc;
    t_pixel             w_pix;

    // stage 1
    logic               r_s1_v;
    logic [XW-1:0]      r_s1_x;
    logic [LANE_BITS-1:0] r_s1_lane;
    t_pixel             r_s1_pix;
    logic               r_s1_y0;
    logic               r_s1_yge32;
    logic               r_s1_yge48;
    logic               r_s1_yge64;
    logic               r_s1_x0;
    logic               r_s1_xge32;
    logic               r_s1_xge48;
    logic               r_s1_xge64;
    logic               r_s1_emit;
    logic [OX_W-1:0]    r_s1_ox;
    logic [OY_W-1:0]    r_s1_oy;

    t_ls_word           w_ls_rd;
    t_col_rec           r_col_rd;
    t_col_rec           r_col_old;
    logic [NUM_CH-1:0][C16_W-1:0] r_b16_rd;
    logic [NUM_CH-1:0][C32_W-1:0] r_b32_rd;

    t_col_rec           r_col_mem [CDEP];
    logic [NUM_CH-1:0][C16_W-1:0] r_buf16 [WIN];
    logic [NUM_CH-1:0][C32_W-1:0] r_buf32 [WIN];

    logic [LANE_BITS-1:0] w_lane48;
    logic [LANE_BITS-1:0] w_lane32;
    t_pixel             w_old;
    t_pixel             w_a48;
    t_pixel             w_a32;
    t_col_rec           w_col_new;

    // stage 2
    logic               r_s2_v;
    logic [NUM_CH-1:0][C64_W-1:0] r_s2_c64;
    t_col_rec           r_s2_old;
    logic [NUM_CH-1:0][C16_W-1:0] r_s2_d16;
    logic [NUM_CH-1:0][C32_W-1:0] r_s2_d32;
    logic               r_s2_x0;
    logic               r_s2_xge32;
    logic               r_s2_xge48;
    logic               r_s2_xge64;
    logic               r_s2_emit;
    logic [OX_W-1:0]    r_s2_ox;
    logic [OY_W-1:0]    r_s2_oy;

    logic [NUM_CH-1:0][S16_W-1:0] r_run16;
    logic [NUM_CH-1:0][S32_W-1:0] r_run32;
    logic [NUM_CH-1:0][S64_W-1:0] r_run64;
    t_result            w_res;
    logic               res_v;

    // output register and skid
    t_result            r_out;
    logic               r_out_v;
    t_result            r_skid;
    logic               r_skid_v;

    assign en         = !r_skid_v;
    assign o_in_stall = r_skid_v;
    assign in_acc     = i_in_valid && en;
    assign w_pix      = {i_chan_third, i_chan_second, i_chan_first};
    assign w_x_ext    = {1'b0, r_pos_x};

    // effective image size, clamped
    always_comb begin
        if (r_img_w < IMG_W_W'(WIN)) begin
            w_last_x = XW'(WIN - 1);
        end else if (IMG_H_W'(r_img_w) > IMG_H_W'(MAX_WIDTH)) begin
            w_last_x = XW'(MAX_WIDTH - 1);
        end else begin
            w_last_x = XW'(r_img_w - IMG_W_W'(1));
        end
        if (r_img_h < IMG_H_W'(WIN)) begin
            w_last_y = OY_W'(WIN - 1);
        end else if (r_img_h > IMG_H_W'(MAX_HEIGHT)) begin
            w_last_y = OY_W'(MAX_HEIGHT - 1);
        end else begin
            w_last_y = OY_W'(r_img_h - IMG_H_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMG_W_W'(IMG_W_RESET);
            r_img_h <= IMG_H_W'(IMG_H_RESET);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMG_WIDTH:  r_img_w <= i_cfg_data[IMG_W_W-1:0];
                CFG_IMG_HEIGHT: r_img_h <= i_cfg_data[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_cfg_we) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (in_acc) begin
            if (r_pos_x == w_last_x) begin
                r_pos_x <= '0;
                r_pos_y <= (r_pos_y == w_last_y) ? '0 : r_pos_y + OY_W'(1);
            end else begin
                r_pos_x <= r_pos_x + XW'(1);
            end
        end
    end

    // stage 0: issue memory reads, write the pixel into its lane
    msbs_line_store #(
        .XW (XW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_en    (in_acc),
        .i_lane  (r_pos_y[ROW_BITS+LANE_BITS-1:ROW_BITS]),
        .i_addr  ({r_pos_y[ROW_BITS-1:0], r_pos_x}),
        .i_wdata (w_pix),
        .o_rdata (w_ls_rd)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col_rd  <= r_col_mem[r_pos_x];
            r_col_old <= r_col_mem[r_pos_x - XW'(WIN)];
            // column x-48 and x-32 of the current row
            r_b16_rd  <= r_buf16[r_pos_x[WIN_BITS-1:0] + WIN_BITS'(QUARTER)];
            r_b32_rd  <= r_buf32[r_pos_x[WIN_BITS-1:0] + WIN_BITS'(HALF)];
        end
        if (en && r_s1_v) begin
            r_col_mem[r_s1_x]                <= w_col_new;
            r_buf16[r_s1_x[WIN_BITS-1:0]]    <= w_col_new.c16;
            r_buf32[r_s1_x[WIN_BITS-1:0]]    <= w_col_new.c32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x     <= r_pos_x;
            r_s1_lane  <= r_pos_y[ROW_BITS+LANE_BITS-1:ROW_BITS];
            r_s1_pix   <= w_pix;
            r_s1_y0    <= (r_pos_y == '0);
            r_s1_yge32 <= (r_pos_y >= OY_W'(WIN - HALF));
            r_s1_yge48 <= (r_pos_y >= OY_W'(WIN - QUARTER));
            r_s1_yge64 <= (r_pos_y >= OY_W'(WIN));
            r_s1_x0    <= (r_pos_x == '0);
            r_s1_xge32 <= (w_x_ext >= XE'(WIN - HALF));
            r_s1_xge48 <= (w_x_ext >= XE'(WIN - QUARTER));
            r_s1_xge64 <= (w_x_ext >= XE'(WIN));
            r_s1_emit  <= (w_x_ext >= XE'(WIN - 1)) && (r_pos_y >= OY_W'(WIN - 1));
            r_s1_ox    <= OX_W'(r_pos_x - XW'(WIN - 1));
            r_s1_oy    <= r_pos_y - OY_W'(WIN - 1);
        end
    end

    // stage 1: update the column sums of this column
    assign w_lane48 = r_s1_lane + LANE_BITS'(1);
    assign w_lane32 = r_s1_lane + LANE_BITS'(2);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_old[c] = r_s1_yge64 ? w_ls_rd[r_s1_lane][c] : '0;
            w_a48[c] = r_s1_yge48 ? w_ls_rd[w_lane48][c] : '0;
            w_a32[c] = r_s1_yge32 ? w_ls_rd[w_lane32][c] : '0;
            w_col_new.c16[c] = (r_s1_y0 ? '0 : r_col_rd.c16[c])
                             + C16_W'(w_a48[c]) - C16_W'(w_old[c]);
            w_col_new.c32[c] = (r_s1_y0 ? '0 : r_col_rd.c32[c])
                             + C32_W'(w_a32[c]) - C32_W'(w_old[c]);
            w_col_new.c64[c] = (r_s1_y0 ? '0 : r_col_rd.c64[c])
                             + C64_W'(r_s1_pix[c]) - C64_W'(w_old[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s1_v) begin
            r_s2_c64   <= w_col_new.c64;
            r_s2_old   <= r_col_old;
            r_s2_d16   <= r_b16_rd;
            r_s2_d32   <= r_b32_rd;
            r_s2_x0    <= r_s1_x0;
            r_s2_xge32 <= r_s1_xge32;
            r_s2_xge48 <= r_s1_xge48;
            r_s2_xge64 <= r_s1_xge64;
            r_s2_emit  <= r_s1_emit;
            r_s2_ox    <= r_s1_ox;
            r_s2_oy    <= r_s1_oy;
        end
    end

    // stage 2: running horizontal sums of the column sums
    always_comb begin
        w_res.origin_x = r_s2_ox;
        w_res.origin_y = r_s2_oy;
        for (int c = 0; c < NUM_CH; c++) begin
            w_res.s16[c] = (r_s2_x0 ? '0 : r_run16[c])
                         + (r_s2_xge48 ? S16_W'(r_s2_d16[c]) : '0)
                         - (r_s2_xge64 ? S16_W'(r_s2_old.c16[c]) : '0);
            w_res.s32[c] = (r_s2_x0 ? '0 : r_run32[c])
                         + (r_s2_xge32 ? S32_W'(r_s2_d32[c]) : '0)
                         - (r_s2_xge64 ? S32_W'(r_s2_old.c32[c]) : '0);
            w_res.s64[c] = (r_s2_x0 ? '0 : r_run64[c])
                         + S64_W'(r_s2_c64[c])
                         - (r_s2_xge64 ? S64_W'(r_s2_old.c64[c]) : '0);
        end
    end

    assign res_v = en && r_s2_v && r_s2_emit;

    always_ff @(posedge i_clk) begin
        if (en && r_s2_v) begin
            r_run16 <= w_res.s16;
            r_run32 <= w_res.s32;
            r_run64 <= w_res.s64;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_out_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= res_v;
            end
        end else if (res_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_out_stall) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (res_v) begin
                r_out <= w_res;
            end
        end else if (res_v) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_origin_x     = r_out.origin_x;
    assign o_origin_y     = r_out.origin_y;
    assign o_sum16_first  = r_out.s16[0];
    assign o_sum16_second = r_out.s16[1];
    assign o_sum16_third  = r_out.s16[2];
    assign o_sum32_first  = r_out.s32[0];
    assign o_sum32_second = r_out.s32[1];
    assign o_sum32_third  = r_out.s32[2];
    assign o_sum64_first  = r_out.s64[0];
    assign o_sum64_second = r_out.s64[1];
    assign o_sum64_third  = r_out.s64[2];

    // skid only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry without a valid output");

    // a full skid freezes the pipeline
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_s1_v) && $stable(r_s2_v))
        else $error("pipeline moved while skid was full");

    a_pos_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_x <= w_last_x)
        else $error("column position beyond the image width");

    // nested squares: 16x16 within 32x32 within 64x64
    a_sums_nested: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (S32_W'(r_out.s16[0]) <= r_out.s32[0])
                 && (S32_W'(r_out.s16[1]) <= r_out.s32[1])
                 && (S32_W'(r_out.s16[2]) <= r_out.s32[2])
                 && (S64_W'(r_out.s32[0]) <= r_out.s64[0])
                 && (S64_W'(r_out.s32[1]) <= r_out.s64[1])
                 && (S64_W'(r_out.s32[2]) <= r_out.s64[2]))
        else $error("box sums are not nested");

endmodule

@@ dv/multi_scale_box_sum_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_scale_box_sum_top_tb
// Streams raster frames through the box sum block under several image sizes,
// predicts every window transaction with a local model of the column and row
// sums, and compares each output transaction field by field, in order.
// ----------------------------------------------------------------------------
module multi_scale_box_sum_top_tb;
    import msbs_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int NO_WRITE     = -1;
    localparam int HOLD_CYCLES  = 400;
    localparam int PIPE_SETTLE  = 16;
    localparam int WR_WIDTH     = 0;
    localparam int WR_HEIGHT    = 1;
    localparam int WR_BOTH      = 2;

    typedef enum {PIX_RANDOM, PIX_FULL, PIX_ZERO} t_pix_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [PIX_W-1:0]   i_chan_first = '0;
    logic [PIX_W-1:0]   i_chan_second = '0;
    logic [PIX_W-1:0]   i_chan_third = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [OX_W-1:0]    o_origin_x;
    logic [OY_W-1:0]    o_origin_y;
    logic [S16_W-1:0]   o_sum16_first, o_sum16_second, o_sum16_third;
    logic [S32_W-1:0]   o_sum32_first, o_sum32_second, o_sum32_third;
    logic [S64_W-1:0]   o_sum64_first, o_sum64_second, o_sum64_third;

    multi_scale_box_sum_top #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_chan_first   (i_chan_first),
        .i_chan_second  (i_chan_second),
        .i_chan_third   (i_chan_third),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_origin_x     (o_origin_x),
        .o_origin_y     (o_origin_y),
        .o_sum16_first  (o_sum16_first),
        .o_sum16_second (o_sum16_second),
        .o_sum16_third  (o_sum16_third),
        .o_sum32_first  (o_sum32_first),
        .o_sum32_second (o_sum32_second),
        .o_sum32_third  (o_sum32_third),
        .o_sum64_first  (o_sum64_first),
        .o_sum64_second (o_sum64_second),
        .o_sum64_third  (o_sum64_third)
    );

    // shadow of the block: line history, column sums, row accumulators
    bit [7:0]    line_hist [NUM_CH][LINE_ROWS*MAX_W];
    int unsigned col16 [NUM_CH][MAX_W];
    int unsigned col32 [NUM_CH][MAX_W];
    int unsigned col64 [NUM_CH][MAX_W];
    int unsigned row_acc [NUM_CH][3];
    int unsigned pos_x = 0;
    int unsigned pos_y = 0;
    int unsigned cfg_width = IMG_W_RESET;
    int unsigned cfg_height = IMG_H_RESET;

    t_pixel  pixels_to_send [$];
    t_result window_sums_due [$];

    int send_idle_pct = 37;
    int stall_pct = 53;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int pixels_taken = 0;
    int windows_checked = 0;
    int cfg_writes = 0;
    int mismatches = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned slot_of(int unsigned row, int unsigned col);
        return (row % LINE_ROWS) * MAX_W + (col % MAX_W);
    endfunction

    function automatic bit predict_window_sums(input t_pixel px, output t_result res);
        int unsigned w, h, x, y, v, s, oldest, a48, a32;
        int c;
        bit emit;
        w = cfg_width;
        if (w < WIN) w = WIN;
        if (w > MAX_W) w = MAX_W;
        h = cfg_height;
        if (h < WIN) h = WIN;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        x = pos_x % MAX_W;
        y = pos_y;
        emit = (x >= WIN - 1) && (y >= WIN - 1);
        res = '0;
        for (c = 0; c < NUM_CH; c++) begin
            v = px[c];
            s = slot_of(y, x);
            oldest = (y >= WIN) ? line_hist[c][s] : 0;
            a48 = (y >= WIN - QUARTER) ? line_hist[c][slot_of(y - (WIN - QUARTER), x)] : 0;
            a32 = (y >= WIN - HALF) ? line_hist[c][slot_of(y - (WIN - HALF), x)] : 0;
            // first row of a frame rebuilds the column sums
            if (y == 0) begin
                col16[c][x] = 0;
                col32[c][x] = 0;
                col64[c][x] = 0;
            end
            col16[c][x] = col16[c][x] + a48 - oldest;
            col32[c][x] = col32[c][x] + a32 - oldest;
            col64[c][x] = col64[c][x] + v - oldest;
            line_hist[c][s] = v;
            if (x == 0) begin
                row_acc[c][0] = 0;
                row_acc[c][1] = 0;
                row_acc[c][2] = 0;
            end
            if (x >= WIN - QUARTER) row_acc[c][0] += col16[c][x - (WIN - QUARTER)];
            if (x >= WIN) row_acc[c][0] -= col16[c][x - WIN];
            if (x >= WIN - HALF) row_acc[c][1] += col32[c][x - (WIN - HALF)];
            if (x >= WIN) row_acc[c][1] -= col32[c][x - WIN];
            row_acc[c][2] += col64[c][x];
            if (x >= WIN) row_acc[c][2] -= col64[c][x - WIN];
            res.s16[c] = S16_W'(row_acc[c][0]);
            res.s32[c] = S32_W'(row_acc[c][1]);
            res.s64[c] = S64_W'(row_acc[c][2]);
        end
        res.origin_x = OX_W'(x - (WIN - 1));
        res.origin_y = OY_W'(y - (WIN - 1));
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        pos_x = x;
        pos_y = y;
        return emit;
    endfunction

    function automatic void check_field(string tag, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, tag, want, got);
            mismatches++;
        end
    endfunction

    // pixel source
    always @(posedge i_clk) begin : pixel_driver
        t_pixel  nxt;
        t_result res;
        bit      busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                if (predict_window_sums({i_chan_third, i_chan_second, i_chan_first}, res))
                    window_sums_due.push_back(res);
                pixels_taken++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pixels_to_send.pop_front();
                    i_in_valid    <= 1'b1;
                    i_chan_first  <= nxt[0];
                    i_chan_second <= nxt[1];
                    i_chan_third  <= nxt[2];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result sink: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin : sink_stall
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin : sum_checker
        t_result want;
        t_result got;
        int c;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (window_sums_due.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual origin (%0d, %0d)",
                         $time, o_origin_x, o_origin_y);
                mismatches++;
            end else begin
                want = window_sums_due.pop_front();
                got.origin_x = o_origin_x;
                got.origin_y = o_origin_y;
                got.s16 = {o_sum16_third, o_sum16_second, o_sum16_first};
                got.s32 = {o_sum32_third, o_sum32_second, o_sum32_first};
                got.s64 = {o_sum64_third, o_sum64_second, o_sum64_first};
                check_field("origin_x", want.origin_x, got.origin_x);
                check_field("origin_y", want.origin_y, got.origin_y);
                for (c = 0; c < NUM_CH; c++) begin
                    check_field($sformatf("sum16 ch%0d", c), want.s16[c], got.s16[c]);
                    check_field($sformatf("sum32 ch%0d", c), want.s32[c], got.s32[c]);
                    check_field($sformatf("sum64 ch%0d", c), want.s64[c], got.s64[c]);
                end
                windows_checked++;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_IMG_WIDTH)
            cfg_width = data[IMG_W_W-1:0];
        else
            cfg_height = data[IMG_H_W-1:0];
        // any write restarts the frame
        pos_x = 0;
        pos_y = 0;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pixels_to_send.size() != 0 || i_in_valid || window_sums_due.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    task automatic run_phase(input int width_word, input int height_word, input int n_pix,
                             input t_pix_mode mode, input bit squeeze);
        t_pixel px;
        int c;
        if (width_word != NO_WRITE) write_reg(CFG_IMG_WIDTH, width_word[CFG_W-1:0]);
        if (height_word != NO_WRITE) write_reg(CFG_IMG_HEIGHT, height_word[CFG_W-1:0]);
        repeat (n_pix) begin
            case (mode)
                PIX_FULL: px = '1;
                PIX_ZERO: px = '0;
                default: begin
                    if ($urandom_range(7) == 0) begin
                        for (c = 0; c < NUM_CH; c++)
                            px[c] = $urandom_range(1) ? 8'hFF : 8'h00;
                    end else begin
                        px = 24'($urandom());
                    end
                end
            endcase
            pixels_to_send.push_back(px);
        end
        // hold the sink off once results flow, so the block backs up
        if (squeeze) begin
            while (window_sums_due.size() == 0) @(negedge i_clk);
            hold_req++;
        end
        drain();
    endtask

    initial begin : timeout_guard
        #12_000_000;
        $display("FAIL multi_scale_box_sum_top");
        $finish;
    end

    initial begin : stimulus
        int cur_w, cur_h, wr_kind, wword, hword, k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short directed burst at the reset size: channel extremes and bit walks
        pixels_to_send.push_back({8'h00, 8'h00, 8'h00});
        pixels_to_send.push_back({8'hFF, 8'hFF, 8'hFF});
        pixels_to_send.push_back({8'h0F, 8'hAA, 8'h55});
        pixels_to_send.push_back({8'hF0, 8'h55, 8'hAA});
        for (k = 0; k < 8; k++)
            pixels_to_send.push_back({~(8'h01 << k), 8'h01 << ((k + 3) % 8), 8'h01 << k});
        for (k = 0; k < 8; k++)
            pixels_to_send.push_back({8'h80 >> k, ~(8'h80 >> k), 8'hFF ^ (8'h01 << k)});
        pixels_to_send.push_back({8'hFF, 8'h00, 8'hFF});
        pixels_to_send.push_back({8'h00, 8'hFF, 8'h00});
        drain();

        // smallest image, saturated pixels: largest sums
        run_phase(WIN, WIN + 2, WIN * (WIN + 2), PIX_FULL, 1'b0);
        // both sizes below range clamp up; one full frame then wrap
        run_phase(0, 3, WIN * WIN + 200, PIX_RANDOM, 1'b0);
        // dense results, long sink hold-off
        run_phase(100, 70, 100 * 70 + 1234, PIX_RANDOM, 1'b1);
        run_phase(WIN - 1, WIN + 1, WIN * (WIN + 1), PIX_ZERO, 1'b0);

        send_idle_pct = 53;
        stall_pct = 37;
        cur_w = WIN;
        cur_h = WIN + 1;
        for (k = 0; k < 4; k++) begin
            wr_kind = (k == 0) ? WR_BOTH : $urandom_range(WR_BOTH);
            wword = NO_WRITE;
            hword = NO_WRITE;
            if (wr_kind != WR_HEIGHT) begin
                cur_w = $urandom_range(96, WIN);
                // upper data bits fall outside the width register
                wword = cur_w | ($urandom_range(3) << IMG_W_W);
            end
            if (wr_kind != WR_WIDTH) begin
                cur_h = $urandom_range(72, WIN);
                hword = cur_h;
            end
            run_phase(wword, hword, cur_w * cur_h + $urandom_range(cur_w * cur_h),
                      PIX_RANDOM, 1'b0);
        end

        send_idle_pct = 0;
        stall_pct = 0;
        // widest rows (width clamps down), shortest frame, then wrap
        run_phase(2047, WIN, MAX_W * WIN + 300, PIX_RANDOM, 1'b0);
        // tallest frame (height clamps down), then wrap
        run_phase(0, 8191, WIN * MAX_HEIGHT + 300, PIX_RANDOM, 1'b0);

        $display("run covered %0d pixels over %0d register writes, %0d window results compared",
                 pixels_taken, cfg_writes, windows_checked);
        $display("field mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("PASS multi_scale_box_sum_top");
        end else begin
            $display("FAIL multi_scale_box_sum_top");
        end
        $finish;
    end

endmodule
